[sv/tbcfp_pkg.sv]
// Package with the command codes, power state codes and frame types of the frame parser.
`timescale 1ns / 1ps
`default_nettype none
package tbcfp_pkg;

  localparam logic [7:0] CMD_X_Y_IDLE = 8'h10;
  localparam logic [7:0] CMD_X_Y      = 8'h11;
  localparam logic [7:0] CMD_X_Y_CLR  = 8'h12;
  localparam logic [7:0] CMD_R_Z_ON   = 8'h20;
  localparam logic [7:0] CMD_R_Z      = 8'h21;
  localparam logic [7:0] CMD_R_Z_CLR  = 8'h22;
  localparam logic [7:0] CMD_OFF      = 8'h44;

  localparam logic [1:0] PS_OFF  = 2'd0;
  localparam logic [1:0] PS_IDLE = 2'd1;
  localparam logic [1:0] PS_ON   = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_REQ_OFF,
    OP_REQ_IDLE,
    OP_REQ_ON,
    OP_LOAD_XY,
    OP_LOAD_RZ,
    OP_CLR_XY,
    OP_CLR_RZ
  } tbcfp_op_e;

  typedef struct packed {
    tbcfp_op_e  op;
    logic [7:0] d1;
    logic [7:0] d2;
  } tbcfp_frame_t;

endpackage
`default_nettype wire

[sv/tbcfp_front.sv]
// Front end: assembles three-byte frames and classifies each finished frame.
`timescale 1ns / 1ps
`default_nettype none
module tbcfp_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          rx_byte_i,
  input  wire logic [1:0]          current_power_state_i,
  input  wire logic                q_full_i,
  output logic                     push_o,
  output tbcfp_pkg::tbcfp_frame_t  frame_o
);
  import tbcfp_pkg::*;

  localparam logic [1:0] CNT_START = 2'd0;
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_TWO   = 2'd2;

  logic [1:0] count_q, count_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] d1_q, d1_d;
  logic       accept;
  logic       frame_last;
  logic       known;
  tbcfp_op_e  op;

  assign frame_last = (count_q == CNT_TWO);
  assign in_stall_o = frame_last && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = accept && frame_last;
  assign known      = rx_byte_i inside {CMD_X_Y_IDLE, CMD_X_Y, CMD_X_Y_CLR, CMD_R_Z_ON,
                                        CMD_R_Z, CMD_R_Z_CLR, CMD_OFF};

  always_comb begin
    case (cmd_q)
      CMD_X_Y_IDLE: op = (current_power_state_i == PS_OFF) ? OP_REQ_IDLE : OP_LOAD_XY;
      CMD_X_Y:      op = OP_LOAD_XY;
      CMD_X_Y_CLR:  op = OP_CLR_XY;
      CMD_R_Z_ON:   op = (current_power_state_i == PS_IDLE) ? OP_REQ_ON : OP_LOAD_RZ;
      CMD_R_Z:      op = OP_LOAD_RZ;
      CMD_R_Z_CLR:  op = OP_CLR_RZ;
      default:      op = OP_REQ_OFF;
    endcase
  end

  assign frame_o = '{op: op, d1: d1_q, d2: rx_byte_i};

  always_comb begin
    count_d = count_q;
    cmd_d   = cmd_q;
    d1_d    = d1_q;
    if (accept) begin
      case (count_q)
        CNT_ONE: begin
          d1_d    = rx_byte_i;
          count_d = CNT_TWO;
        end
        CNT_TWO: begin
          count_d = CNT_START;
        end
        default: begin
          if (known) begin
            cmd_d   = rx_byte_i;
            count_d = CNT_ONE;
          end else begin
            count_d = CNT_START;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_START;
      cmd_q   <= '0;
      d1_q    <= '0;
    end else begin
      count_q <= count_d;
      cmd_q   <= cmd_d;
      d1_q    <= d1_d;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("Frame byte count left its range.");

  a_push_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> count_q == CNT_START) else $error("A frame was pushed mid-frame.");

  a_cmd_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != CNT_START |-> (cmd_q == CMD_X_Y_IDLE || cmd_q == CMD_X_Y ||
    cmd_q == CMD_X_Y_CLR || cmd_q == CMD_R_Z_ON || cmd_q == CMD_R_Z ||
    cmd_q == CMD_R_Z_CLR || cmd_q == CMD_OFF))
    else $error("A frame started with an unknown command.");

endmodule
`default_nettype wire

[sv/tbcfp_queue.sv]
// Small queue of classified frames between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module tbcfp_queue #(
  parameter int unsigned Depth = tbcfp_pkg::QUEUE_DEPTH
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push_i,
  input  wire tbcfp_pkg::tbcfp_frame_t  data_i,
  output logic                          full_o,
  input  wire logic                     pop_i,
  output logic                          valid_o,
  output tbcfp_pkg::tbcfp_frame_t       data_o
);
  import tbcfp_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  tbcfp_frame_t    mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull) else $error("Queue count exceeds its depth.");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
    else $error("Queue count did not grow on a push.");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("Item pushed into a full queue.");

endmodule
`default_nettype wire

[sv/tbcfp_back.sv]
// Back end: carries out classified frames on the held axis values and drives the result register.
`timescale 1ns / 1ps
`default_nettype none
module tbcfp_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     q_valid_i,
  input  wire tbcfp_pkg::tbcfp_frame_t  q_data_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          request_valid_o,
  output logic [1:0]                    requested_state_o,
  output logic signed [7:0]             x_value_o,
  output logic signed [7:0]             y_value_o,
  output logic signed [7:0]             z_value_o,
  output logic signed [7:0]             rotation_value_o
);
  import tbcfp_pkg::*;

  logic [7:0] x_q, x_d, y_q, y_d, z_q, z_d, rot_q, rot_d;
  logic       req_valid;
  logic [1:0] req_state;
  logic       out_valid_q;
  logic       res_req_q;
  logic [1:0] res_state_q;
  logic [7:0] res_x_q, res_y_q, res_z_q, res_rot_q;

  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    rot_d     = rot_q;
    req_valid = 1'b0;
    req_state = PS_OFF;
    case (q_data_i.op)
      OP_REQ_OFF: begin
        req_valid = 1'b1;
        req_state = PS_OFF;
      end
      OP_REQ_IDLE: begin
        req_valid = 1'b1;
        req_state = PS_IDLE;
      end
      OP_REQ_ON: begin
        req_valid = 1'b1;
        req_state = PS_ON;
      end
      OP_LOAD_XY: begin
        x_d = q_data_i.d1;
        y_d = q_data_i.d2;
      end
      OP_LOAD_RZ: begin
        rot_d = q_data_i.d1;
        z_d   = q_data_i.d2;
      end
      OP_CLR_XY: begin
        x_d = '0;
        y_d = '0;
      end
      OP_CLR_RZ: begin
        z_d   = '0;
        rot_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      rot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        x_q         <= x_d;
        y_q         <= y_d;
        z_q         <= z_d;
        rot_q       <= rot_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_req_q   <= req_valid;
      res_state_q <= req_state;
      res_x_q     <= x_d;
      res_y_q     <= y_d;
      res_z_q     <= z_d;
      res_rot_q   <= rot_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign request_valid_o   = res_req_q;
  assign requested_state_o = res_state_q;
  assign x_value_o         = signed'(res_x_q);
  assign y_value_o         = signed'(res_y_q);
  assign z_value_o         = signed'(res_z_q);
  assign rotation_value_o  = signed'(res_rot_q);

  a_state_zero_without_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_req_q |-> res_state_q == PS_OFF)
    else $error("Requested state is set without a request.");

  a_request_keeps_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && req_valid |=> x_q == $past(x_q) && z_q == $past(z_q))
    else $error("A power request changed the held values.");

  a_result_matches_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> res_x_q == x_q && res_rot_q == rot_q)
    else $error("Result register disagrees with the held values.");

endmodule
`default_nettype wire

[sv/three_byte_command_frame_parser.sv]
// A frame is pushed into the frame queue when its third byte is accepted, then popped into the result register.
// Throughput: one byte per cycle while in_stall_o is low; one result per three bytes, set by the frame assembler.
// A two-entry frame queue lets the front take bytes while the result register is stalled.
// Reset is asynchronous and active low; it clears the frame count and all held axis values.
// Output payload registers are not reset; they are loaded with each result.
`timescale 1ns / 1ps
`default_nettype none
module three_byte_command_frame_parser #(
  parameter int unsigned QueueDepth = tbcfp_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [1:0]  current_power_state_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             request_valid_o,
  output logic [1:0]       requested_state_o,
  output logic signed [7:0] x_value_o,
  output logic signed [7:0] y_value_o,
  output logic signed [7:0] z_value_o,
  output logic signed [7:0] rotation_value_o
);
  import tbcfp_pkg::*;

  tbcfp_frame_t push_frame, pop_frame;
  logic         push, q_full, q_valid, pop;

  tbcfp_front u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .rx_byte_i             (rx_byte_i),
    .current_power_state_i (current_power_state_i),
    .q_full_i              (q_full),
    .push_o                (push),
    .frame_o               (push_frame)
  );

  tbcfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_frame),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pop_frame)
  );

  tbcfp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_data_i          (pop_frame),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .request_valid_o   (request_valid_o),
    .requested_state_o (requested_state_o),
    .x_value_o         (x_value_o),
    .y_value_o         (y_value_o),
    .z_value_o         (z_value_o),
    .rotation_value_o  (rotation_value_o)
  );

endmodule
`default_nettype wire

[tb/frame_checker.sv]
// Checker that predicts each frame result of the parser and compares it with the block output.
`timescale 1ns / 1ps
module frame_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_stall_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic [1:0] current_power_state_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_stall_i,
  input  wire logic       request_valid_i,
  input  wire logic [1:0] requested_state_i,
  input  wire logic [7:0] x_value_i,
  input  wire logic [7:0] y_value_i,
  input  wire logic [7:0] z_value_i,
  input  wire logic [7:0] rotation_value_i,
  output int              fail_count_o,
  output int              pending_o
);
  import tbcfp_pkg::*;

  typedef struct packed {
    logic       req_valid;
    logic [1:0] req_state;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] z;
    logic [7:0] rot;
  } frame_result_t;

  logic [1:0]    bytes_seen;
  logic [7:0]    cmd_q;
  logic [7:0]    data1_q;
  logic [7:0]    x_q;
  logic [7:0]    y_q;
  logic [7:0]    z_q;
  logic [7:0]    rot_q;
  frame_result_t expected_results[$];

  function automatic logic is_command(logic [7:0] b);
    return b inside {CMD_X_Y_IDLE, CMD_X_Y, CMD_X_Y_CLR, CMD_R_Z_ON, CMD_R_Z, CMD_R_Z_CLR,
                     CMD_OFF};
  endfunction

  // Advances the frame assembler by one byte and queues a result on the third byte.
  task automatic assemble_byte(input logic [7:0] b, input logic [1:0] ps);
    frame_result_t r;
    if (bytes_seen == 2'd1) begin
      data1_q = b;
      bytes_seen = 2'd2;
    end else if (bytes_seen == 2'd2) begin
      bytes_seen = 2'd0;
      r = '0;
      if (cmd_q == CMD_OFF) begin
        r.req_valid = 1'b1;
        r.req_state = PS_OFF;
      end else if (ps == PS_OFF && cmd_q == CMD_X_Y_IDLE) begin
        r.req_valid = 1'b1;
        r.req_state = PS_IDLE;
      end else if (ps == PS_IDLE && cmd_q == CMD_R_Z_ON) begin
        r.req_valid = 1'b1;
        r.req_state = PS_ON;
      end else if (cmd_q == CMD_X_Y_IDLE || cmd_q == CMD_X_Y) begin
        x_q = data1_q;
        y_q = b;
      end else if (cmd_q == CMD_R_Z_ON || cmd_q == CMD_R_Z) begin
        rot_q = data1_q;
        z_q = b;
      end else if (cmd_q == CMD_X_Y_CLR) begin
        x_q = '0;
        y_q = '0;
      end else if (cmd_q == CMD_R_Z_CLR) begin
        z_q = '0;
        rot_q = '0;
      end
      r.x = x_q;
      r.y = y_q;
      r.z = z_q;
      r.rot = rot_q;
      expected_results.push_back(r);
    end else begin
      bytes_seen = 2'd0;
      if (is_command(b)) begin
        cmd_q = b;
        bytes_seen = 2'd1;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
    if (act !== exp) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t e;
    if (!rst_ni) begin
      bytes_seen = '0;
      cmd_q = '0;
      data1_q = '0;
      x_q = '0;
      y_q = '0;
      z_q = '0;
      rot_q = '0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, actual x %0d y %0d z %0d rot %0d",
                   $time, x_value_i, y_value_i, z_value_i, rotation_value_i);
          fail_count_o++;
        end else begin
          e = expected_results.pop_front();
          check_field("request_valid", 8'(e.req_valid), 8'(request_valid_i));
          check_field("requested_state", 8'(e.req_state), 8'(requested_state_i));
          check_field("x_value", e.x, x_value_i);
          check_field("y_value", e.y, y_value_i);
          check_field("z_value", e.z, z_value_i);
          check_field("rotation_value", e.rot, rotation_value_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        assemble_byte(rx_byte_i, current_power_state_i);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

[tb/tb.sv]
// Testbench top that drives bytes into the frame parser, stalls its output and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import tbcfp_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic [1:0]  current_power_state_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        request_valid_o;
  logic [1:0]  requested_state_o;
  logic signed [7:0] x_value_o;
  logic signed [7:0] y_value_o;
  logic signed [7:0] z_value_o;
  logic signed [7:0] rotation_value_o;
  int          fail_count;
  int          pending;
  bit          calm;

  logic [7:0] known_cmds[7] = '{CMD_X_Y_IDLE, CMD_X_Y, CMD_X_Y_CLR, CMD_R_Z_ON, CMD_R_Z,
                                CMD_R_Z_CLR, CMD_OFF};

  three_byte_command_frame_parser u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .rx_byte_i             (rx_byte_i),
    .current_power_state_i (current_power_state_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .request_valid_o       (request_valid_o),
    .requested_state_o     (requested_state_o),
    .x_value_o             (x_value_o),
    .y_value_o             (y_value_o),
    .z_value_o             (z_value_o),
    .rotation_value_o      (rotation_value_o)
  );

  frame_checker u_checker (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_i            (in_stall_o),
    .rx_byte_i             (rx_byte_i),
    .current_power_state_i (current_power_state_i),
    .out_valid_i           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .request_valid_i       (request_valid_o),
    .requested_state_i     (requested_state_o),
    .x_value_i             (x_value_o),
    .y_value_i             (y_value_o),
    .z_value_i             (z_value_o),
    .rotation_value_i      (rotation_value_o),
    .fail_count_o          (fail_count),
    .pending_o             (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic [1:0] ps);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    current_power_state_i <= ps;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] c, input logic [7:0] d1, input logic [7:0] d2,
                            input logic [1:0] ps);
    send_byte(c, ps);
    send_byte(d1, ps);
    send_byte(d2, ps);
  endtask

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      3: return 8'hFF;
      4: return known_cmds[$urandom_range(0, 6)];
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Output side: a random stall before each result is taken.
  initial begin
    int waits;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      waits = calm ? 0 : $urandom_range(0, 15);
      if (waits > 0) begin
        out_stall_i <= 1'b1;
        repeat (waits) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    int frame_bytes;
    int frames;
    int drain;
    in_valid_i = 1'b0;
    rx_byte_i = 8'h00;
    current_power_state_i = PS_OFF;
    rst_ni = 1'b0;
    calm = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unknown first bytes are dropped, then every command and the power state cases.
    send_byte(8'h00, PS_ON);
    send_byte(8'hFF, PS_ON);
    send_frame(CMD_X_Y, 8'h7F, 8'h80, PS_ON);
    send_frame(CMD_R_Z, 8'h80, 8'h7F, PS_ON);
    send_frame(CMD_X_Y_IDLE, 8'h01, 8'h02, PS_OFF);
    send_frame(CMD_R_Z_ON, 8'h03, 8'h04, PS_IDLE);
    send_frame(CMD_X_Y_CLR, 8'hFF, 8'hFF, PS_ON);
    send_frame(CMD_R_Z_CLR, 8'h00, 8'h00, PS_ON);
    send_frame(CMD_OFF, 8'hAA, 8'h55, PS_ON);
    send_frame(CMD_X_Y_IDLE, 8'hFF, 8'h00, 2'd3);

    frame_bytes = 0;
    frames = 0;
    while (frame_bytes < 970) begin
      if (frames % 48 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 15) begin
        send_byte(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
      end else begin
        send_byte(known_cmds[$urandom_range(0, 6)], 2'($urandom_range(0, 3)));
        send_byte(pick_data(), 2'($urandom_range(0, 3)));
        send_byte(pick_data(), 2'($urandom_range(0, 3)));
        frame_bytes += 3;
        frames++;
      end
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    drain = 0;
    while (pending != 0 && drain < 5000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (8) @(posedge clk_i);
    if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
